### rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and codes for the timer pool scheduler: operation and result
// codes, controller states, the per-cell command word and the scan token.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Widest slot index the token can carry (pool of up to 64 timers)
  localparam int IDX_MAX_W = 6;
  localparam int NOW_W     = 64;
  localparam int PERIOD_W  = 40;
  localparam int TAG_W     = 16;
  localparam int RES_W     = 32;
  localparam int TICKS_W   = 16;
  localparam int PROD_W    = RES_W + TICKS_W;
  localparam int FIRE_W    = 5;
  localparam logic [FIRE_W-1:0] MAX_FIRE = 5'd16;
  localparam logic [RES_W-1:0]  RES_RESET = 32'd1000000;

  // Operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  // Result kinds
  localparam logic [2:0] RK_FIRED    = 3'd0;
  localparam logic [2:0] RK_ADDED    = 3'd1;
  localparam logic [2:0] RK_DONE     = 3'd2;
  localparam logic [2:0] RK_FULL     = 3'd3;
  localparam logic [2:0] RK_INACTIVE = 3'd4;
  localparam logic [2:0] RK_NONE     = 3'd5;
  localparam logic [2:0] RK_INVALID  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_MUL,
    ST_ADV,
    ST_GO,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH
  } tps_state_t;

  // Command broadcast to every cell; idx selects the target cell
  typedef struct packed {
    logic                 add;
    logic                 del;
    logic                 modify;
    logic                 fire;
    logic                 clr_done;
    logic [IDX_MAX_W-1:0] idx;
    logic [PERIOD_W-1:0]  period;
    logic                 periodic;
    logic [TAG_W-1:0]     handler;
    logic [TAG_W-1:0]     ctx;
    logic [NOW_W-1:0]     now;
  } tps_cmd_t;

  // Scan token handed from cell to cell: earliest expired timer so far
  typedef struct packed {
    logic                 go;
    logic                 found;
    logic [NOW_W-1:0]     expiry;
    logic [IDX_MAX_W-1:0] idx;
    logic                 periodic;
    logic [TAG_W-1:0]     handler;
    logic [TAG_W-1:0]     ctx;
  } tps_tok_t;

endpackage

### rtl/tps_cell.sv
// ----------------------------------------------------------------------------
// tps_cell
// One timer slot. Holds its expiry, period, tags and flags, applies the
// broadcast command when selected, and folds itself into the scan token.
// ----------------------------------------------------------------------------
module tps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tps_pkg::tps_cmd_t cmd,
  input  tps_pkg::tps_tok_t tok_in,
  output tps_pkg::tps_tok_t tok_out,
  output logic             busy
);
  import tps_pkg::*;

  logic                done;
  logic [NOW_W-1:0]    expiry;
  logic [PERIOD_W-1:0] period;
  logic                periodic;
  logic [TAG_W-1:0]    handler;
  logic [TAG_W-1:0]    ctx;
  logic                sel;
  logic                expired;
  logic                take;

  assign sel = (cmd.idx == IDX_MAX_W'(CELL_IDX));

  // Track busy and fired-this-tick flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.clr_done) begin
        done <= 1'b0;
      end
      if (sel && cmd.add) begin
        busy <= 1'b1;
      end
      if (sel && cmd.del) begin
        busy <= 1'b0;
      end
      if (sel && cmd.fire) begin
        done <= 1'b1;
        if (!periodic) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Write slot payload
  always_ff @(posedge clk) begin
    if (sel && cmd.add) begin
      expiry   <= cmd.now + NOW_W'(cmd.period);
      period   <= cmd.period;
      periodic <= cmd.periodic;
      handler  <= cmd.handler;
      ctx      <= cmd.ctx;
    end else if (sel && cmd.modify) begin
      if (cmd.handler != '0) begin
        handler <= cmd.handler;
      end
      if (cmd.ctx != '0) begin
        ctx <= cmd.ctx;
      end
      if (cmd.period != '0) begin
        expiry <= cmd.now + NOW_W'(cmd.period);
      end
    end else if (sel && cmd.fire && periodic) begin
      expiry <= cmd.now + NOW_W'(period);
    end
  end

  // Replace the token only on a strictly earlier expiry: ties stay lower
  assign expired = busy && !done && (expiry <= cmd.now);
  assign take    = expired && (!tok_in.found || (expiry < tok_in.expiry));

  // Hand the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (take) begin
      tok_out.go       <= tok_in.go;
      tok_out.found    <= 1'b1;
      tok_out.expiry   <= expiry;
      tok_out.idx      <= IDX_MAX_W'(CELL_IDX);
      tok_out.periodic <= periodic;
      tok_out.handler  <= handler;
      tok_out.ctx      <= ctx;
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

### rtl/timer_pool_scheduler_core.sv
// ----------------------------------------------------------------------------
// timer_pool_scheduler_core
// Pool of one-shot and periodic timers built as a chain of slot cells, with
// a controller that runs commands and walks expired timers in expiry order.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid/in_stall   | operation slot period_ns periodic
//           |                     | handler_tag context_tag ticks_elapsed
//  output   | out_valid/out_stall | result_kind result_slot fired_handler
//           |                     | fired_context in_use last
//  config   | cfg_we/cfg_data     | resolution_ns
//
//  Add, delete and modify finish once the output register is free.
//  A tick multiplies ticks by resolution, advances time, then scans the cell
//  chain: one scan per fired timer and a final one that finds none, which
//  is skipped after the sixteenth fire. Output stalls can hold a tick up.
//  One item is in work at a time; in_stall is high until it completes.
//  Reset clears busy flags, time and count, and sets resolution to 1000000 ns.
// ----------------------------------------------------------------------------
module timer_pool_scheduler_core #(
  parameter int POOL_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  slot,
  input  logic [39:0] period_ns,
  input  logic        periodic,
  input  logic [15:0] handler_tag,
  input  logic [15:0] context_tag,
  input  logic [15:0] ticks_elapsed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [3:0]  result_slot,
  output logic [15:0] fired_handler,
  output logic [15:0] fired_context,
  output logic [4:0]  in_use,
  output logic        last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import tps_pkg::*;

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);

  tps_state_t state, state_next;

  logic [RES_W-1:0]    resolution;
  logic [NOW_W-1:0]    now;
  logic [CNT_W-1:0]    count, count_next;
  logic [PROD_W-1:0]   prod;
  logic [FIRE_W-1:0]   fire_n;

  // Captured command word
  logic [1:0]          op_r;
  logic [3:0]          slot_r;
  logic [PERIOD_W-1:0] period_r;
  logic                periodic_r;
  logic [TAG_W-1:0]    handler_r;
  logic [TAG_W-1:0]    ctx_r;
  logic [TICKS_W-1:0]  ticks_r;

  // Scan winner and the fired result held back until last is known
  tps_tok_t            win;
  logic                pend_valid;
  logic [3:0]          pend_slot;
  logic [TAG_W-1:0]    pend_handler;
  logic [TAG_W-1:0]    pend_ctx;
  logic [4:0]          pend_in_use;
  logic                pend_load;

  tps_cmd_t            cmd;
  tps_tok_t            tok_chain [POOL_SIZE+1];
  logic [POOL_SIZE-1:0] busy_vec;

  logic                out_ok;
  logic                out_load;
  logic [2:0]          o_kind;
  logic [3:0]          o_slot;
  logic [TAG_W-1:0]    o_handler;
  logic [TAG_W-1:0]    o_ctx;
  logic                o_last;

  logic                any_free;
  logic [IDX_W-1:0]    free_idx;
  logic                add_bad;
  logic                slot_active;

  // Cell chain
  assign tok_chain[0] = '{go: (state == ST_GO), default: '0};

  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    tps_cell #(.CELL_IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok_chain[g]),
      .tok_out (tok_chain[g+1]),
      .busy    (busy_vec[g])
    );
  end

  // Find the lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!busy_vec[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign add_bad     = (period_r == '0) || (handler_r == '0) || (ctx_r == '0);
  assign slot_active = (32'(slot_r) < POOL_SIZE) && busy_vec[IDX_W'(slot_r)];
  assign out_ok      = !out_valid || !out_stall;
  assign in_stall    = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (operation == OP_TICK) ? ST_MUL : ST_CMD;
        end
      end
      ST_CMD: begin
        if (out_ok) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL:  state_next = ST_ADV;
      ST_ADV:  state_next = ST_GO;
      ST_GO:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (tok_chain[POOL_SIZE].go) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!win.found) begin
          state_next = ST_FLUSH;
        end else if (!pend_valid || out_ok) begin
          state_next = (fire_n == MAX_FIRE - 5'd1) ? ST_FLUSH : ST_GO;
        end
      end
      ST_FLUSH: begin
        if (out_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    cmd          = '0;
    cmd.now      = now;
    cmd.period   = period_r;
    cmd.periodic = periodic_r;
    cmd.handler  = handler_r;
    cmd.ctx      = ctx_r;
    count_next   = count;
    out_load     = 1'b0;
    pend_load    = 1'b0;
    o_kind       = RK_NONE;
    o_slot       = '0;
    o_handler    = '0;
    o_ctx        = '0;
    o_last       = 1'b1;
    case (state)
      ST_CMD: begin
        if (out_ok) begin
          out_load = 1'b1;
          if (op_r == OP_ADD) begin
            if (add_bad) begin
              o_kind = RK_INVALID;
            end else if (!any_free) begin
              o_kind = RK_FULL;
            end else begin
              cmd.add    = 1'b1;
              cmd.idx    = IDX_MAX_W'(free_idx);
              count_next = count + CNT_W'(1);
              o_kind     = RK_ADDED;
              o_slot     = 4'(free_idx);
            end
          end else begin
            o_slot  = slot_r;
            cmd.idx = IDX_MAX_W'(slot_r);
            if (!slot_active) begin
              o_kind = RK_INACTIVE;
            end else begin
              o_kind = RK_DONE;
              if (op_r == OP_DELETE) begin
                cmd.del    = 1'b1;
                count_next = count - CNT_W'(1);
              end else begin
                cmd.modify = 1'b1;
              end
            end
          end
        end
      end
      ST_ADV: begin
        cmd.clr_done = 1'b1;
      end
      ST_DECIDE: begin
        if (win.found && (!pend_valid || out_ok)) begin
          cmd.fire  = 1'b1;
          cmd.idx   = win.idx;
          pend_load = 1'b1;
          if (!win.periodic) begin
            count_next = count - CNT_W'(1);
          end
          if (pend_valid) begin
            out_load  = 1'b1;
            o_kind    = RK_FIRED;
            o_slot    = pend_slot;
            o_handler = pend_handler;
            o_ctx     = pend_ctx;
            o_last    = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (out_ok) begin
          out_load = 1'b1;
          if (pend_valid) begin
            o_kind    = RK_FIRED;
            o_slot    = pend_slot;
            o_handler = pend_handler;
            o_ctx     = pend_ctx;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      resolution <= RES_RESET;
      now        <= '0;
      count      <= '0;
      fire_n     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        resolution <= cfg_data;
      end
      if (state == ST_ADV) begin
        now        <= now + NOW_W'(prod);
        fire_n     <= '0;
        pend_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
        fire_n     <= fire_n + 5'd1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      op_r       <= operation;
      slot_r     <= slot;
      period_r   <= period_ns;
      periodic_r <= periodic;
      handler_r  <= handler_tag;
      ctx_r      <= context_tag;
      ticks_r    <= ticks_elapsed;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(ticks_r) * PROD_W'(resolution);
    end
    if ((state == ST_SCAN) && tok_chain[POOL_SIZE].go) begin
      win <= tok_chain[POOL_SIZE];
    end
    if (pend_load) begin
      pend_slot    <= 4'(win.idx);
      pend_handler <= win.handler;
      pend_ctx     <= win.ctx;
      pend_in_use  <= 5'(count_next);
    end
    if (out_load) begin
      result_kind   <= o_kind;
      result_slot   <= o_slot;
      fired_handler <= o_handler;
      fired_context <= o_ctx;
      in_use        <= (state == ST_CMD) ? 5'(count_next) :
                       (pend_valid ? pend_in_use : 5'(count));
      last          <= o_last;
    end
  end

endmodule

### tb/sv/timer_pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_pool_checker
// Watches the command and result channels of the timer pool scheduler,
// predicts every result word from its own copy of the pool state and
// compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module timer_pool_checker
  import tps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  slot,
  input  logic [39:0] period_ns,
  input  logic        periodic,
  input  logic [15:0] handler_tag,
  input  logic [15:0] context_tag,
  input  logic [15:0] ticks_elapsed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  result_kind,
  input  logic [3:0]  result_slot,
  input  logic [15:0] fired_handler,
  input  logic [15:0] fired_context,
  input  logic [4:0]  in_use,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          fired_seen,
  output int          words_seen
);

  localparam int POOL = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] handler;
    logic [15:0] ctx;
    logic [4:0]  used;
    logic        last;
  } result_word_t;

  result_word_t expected_results[$];

  logic [31:0] res_ns;
  logic [63:0] now;
  logic [63:0] expiry [POOL];
  logic [39:0] period [POOL];
  logic        reload [POOL];
  logic [15:0] handler [POOL];
  logic [15:0] ctx [POOL];
  logic        busy [POOL];
  logic [4:0]  used;

  function automatic result_word_t make_word(logic [2:0] k, logic [3:0] s,
                                             logic [15:0] h, logic [15:0] c,
                                             logic l);
    result_word_t w;
    w.kind = k; w.slot = s; w.handler = h; w.ctx = c; w.used = used; w.last = l;
    return w;
  endfunction

  // Advance time, then emit expired timers earliest first, lower slot on ties
  task automatic run_tick(logic [15:0] ticks);
    logic done [POOL];
    int   n;
    int   best;
    for (int i = 0; i < POOL; i++) done[i] = 1'b0;
    now = now + 64'(ticks) * 64'(res_ns);
    n = 0;
    while (n < 16) begin
      best = -1;
      for (int i = 0; i < POOL; i++) begin
        if (busy[i] && !done[i] && expiry[i] <= now)
          if (best < 0 || expiry[i] < expiry[best]) best = i;
      end
      if (best < 0) break;
      done[best] = 1'b1;
      if (reload[best]) begin
        expiry[best] = now + 64'(period[best]);
      end else begin
        busy[best] = 1'b0;
        used--;
      end
      expected_results.push_back(make_word(RK_FIRED, 4'(best), handler[best],
                                           ctx[best], 1'b0));
      n++;
    end
    if (n == 0) expected_results.push_back(make_word(RK_NONE, '0, '0, '0, 1'b1));
    else expected_results[$].last = 1'b1;
  endtask

  // Apply one accepted command word to the predicted pool
  task automatic predict_command();
    int free_slot;
    case (operation)
      OP_TICK: run_tick(ticks_elapsed);
      OP_ADD: begin
        free_slot = -1;
        for (int i = POOL - 1; i >= 0; i--) if (!busy[i]) free_slot = i;
        if (period_ns == 0 || handler_tag == 0 || context_tag == 0) begin
          expected_results.push_back(make_word(RK_INVALID, '0, '0, '0, 1'b1));
        end else if (free_slot < 0) begin
          expected_results.push_back(make_word(RK_FULL, '0, '0, '0, 1'b1));
        end else begin
          busy[free_slot] = 1'b1;
          period[free_slot] = period_ns;
          reload[free_slot] = periodic;
          handler[free_slot] = handler_tag;
          ctx[free_slot] = context_tag;
          expiry[free_slot] = now + 64'(period_ns);
          used++;
          expected_results.push_back(make_word(RK_ADDED, 4'(free_slot), '0, '0,
                                               1'b1));
        end
      end
      default: begin
        if (!busy[slot]) begin
          expected_results.push_back(make_word(RK_INACTIVE, slot, '0, '0, 1'b1));
        end else begin
          if (operation == OP_DELETE) begin
            busy[slot] = 1'b0;
            used--;
          end else begin
            if (handler_tag != 0) handler[slot] = handler_tag;
            if (context_tag != 0) ctx[slot] = context_tag;
            if (period_ns != 0) expiry[slot] = now + 64'(period_ns);
          end
          expected_results.push_back(make_word(RK_DONE, slot, '0, '0, 1'b1));
        end
      end
    endcase
  endtask

  // Track config, predict on accepted commands, compare accepted results
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (rst) begin
      res_ns = RES_RESET;
      now = '0;
      used = '0;
      for (int i = 0; i < POOL; i++) busy[i] = 1'b0;
      expected_results.delete();
      errors = 0;
      fired_seen = 0;
      words_seen = 0;
      pending = 0;
    end else begin
      if (cfg_we) res_ns = cfg_data;
      if (in_valid && !in_stall) predict_command();
      if (out_valid && !out_stall) begin
        got.kind = result_kind; got.slot = result_slot;
        got.handler = fired_handler; got.ctx = fired_context;
        got.used = in_use; got.last = last;
        words_seen++;
        if (result_kind == RK_FIRED) fired_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word at %0t: %p", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("result word differs at %0t: expected %p actual %p",
                       $realtime, want, got);
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands, ticks and resolution changes into the timer pool
// scheduler under several idle and stall mixes, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tps_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [3:0]  slot;
  logic [39:0] period_ns;
  logic        periodic;
  logic [15:0] handler_tag;
  logic [15:0] context_tag;
  logic [15:0] ticks_elapsed;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  result_kind;
  logic [3:0]  result_slot;
  logic [15:0] fired_handler;
  logic [15:0] fired_context;
  logic [4:0]  in_use;
  logic        last;
  logic        cfg_we;
  logic [31:0] cfg_data;

  int errors;
  int pending;
  int fired_seen;
  int words_seen;
  int words_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_off;
  logic hold_req;
  logic hold_used;

  timer_pool_scheduler_core #(.POOL_SIZE(16)) dut (.*);
  timer_pool_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timer_pool_scheduler_core: mismatch");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off once it is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_off  <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      out_stall <= 1'b1;
      hold_off  <= 400;
      hold_used <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one command word, idling first, and hold it until taken
  task automatic send(logic [1:0] op, logic [3:0] s, logic [39:0] p, logic per,
                      logic [15:0] h, logic [15:0] c, logic [15:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op; slot <= s; period_ns <= p; periodic <= per;
    handler_tag <= h; context_tag <= c; ticks_elapsed <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid, then wait until every expected word has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [39:0] rand_period();
    case ($urandom_range(3))
      0: return 40'($urandom_range(1, 3)) * 40'd1000000;
      1: return 40'($urandom_range(1, 20000000));
      2: return {8'($urandom), 32'($urandom)} | 40'd1;
      default: return 40'($urandom_range(1, 8)) * 40'd500000;
    endcase
  endfunction

  // Mostly adds and small ticks, some deletes, modifies and malformed words
  task automatic random_word();
    int pick;
    logic [15:0] h;
    logic [15:0] c;
    pick = $urandom_range(99);
    h = 16'($urandom); c = 16'($urandom);
    if (pick < 35) begin
      send(OP_ADD, 4'($urandom), ($urandom_range(9) == 0) ? 40'd0 : rand_period(),
           1'($urandom), ($urandom_range(15) == 0) ? 16'd0 : h | 16'd1,
           ($urandom_range(15) == 0) ? 16'd0 : c | 16'd1, 16'($urandom));
    end else if (pick < 65) begin
      send(OP_TICK, 4'($urandom), 40'({$urandom, $urandom}), 1'($urandom), h, c,
           ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
    end else if (pick < 80) begin
      send(OP_DELETE, 4'($urandom), 40'({$urandom, $urandom}), 1'($urandom), h, c,
           16'($urandom));
    end else begin
      send(OP_MODIFY, 4'($urandom), ($urandom_range(1) == 0) ? 40'd0 : rand_period(),
           1'($urandom), ($urandom_range(2) == 0) ? 16'd0 : h,
           ($urandom_range(2) == 0) ? 16'd0 : c, 16'($urandom));
    end
  endtask

  // Drain all expected words, let the block settle, then write resolution
  task automatic set_resolution(logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_TICK; slot = '0; period_ns = '0; periodic = 1'b0;
    handler_tag = '0; context_tag = '0; ticks_elapsed = '0;
    cfg_we = 1'b0; cfg_data = '0;
    send_idle_pct = 0; stall_pct = 0; hold_req = 1'b0; words_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: invalid adds, inactive slots, empty tick, extremes
    send(OP_ADD, 0, 40'd0, 1'b0, 16'h1, 16'h1, 0);
    send(OP_ADD, 0, 40'd5, 1'b0, 16'h0, 16'h1, 0);
    send(OP_ADD, 0, 40'd5, 1'b0, 16'h1, 16'h0, 0);
    send(OP_DELETE, 4'd15, 40'd0, 1'b0, 0, 0, 0);
    send(OP_MODIFY, 4'd3, 40'd7, 1'b1, 16'hffff, 16'hffff, 16'hffff);
    send(OP_TICK, 0, 0, 0, 0, 0, 16'd0);
    // Fill the pool: equal expiries tie to lower slot, then one more is full
    for (int i = 0; i < 16; i++)
      send(OP_ADD, 0, (i < 8) ? 40'd2000000 : 40'hff_ffff_ffff, 1'(i & 1),
           16'hffff - 16'(i), 16'(i + 1), 0);
    send(OP_ADD, 0, 40'd1, 1'b0, 16'h1, 16'h1, 0);
    send(OP_MODIFY, 4'd2, 40'd1000000, 1'b0, 16'h0, 16'h0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0, 16'd2);
    send(OP_DELETE, 4'd15, 0, 0, 0, 0, 0);
    set_resolution(32'd0);
    send(OP_TICK, 0, 0, 0, 0, 0, 16'hffff);
    set_resolution(32'hffff_ffff);
    send(OP_TICK, 0, 0, 0, 0, 0, 16'hffff);
    set_resolution(32'd1);

    // Random phases under different idle and stall mixes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        3: begin send_idle_pct = 26; stall_pct = 26; end
        default: begin send_idle_pct = 0; stall_pct = 10; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < 88; n++) random_word();
      case (ph)
        0: set_resolution(32'd1000000);
        1: set_resolution(32'd333);
        2: set_resolution(32'd1000000000);
        3: set_resolution(32'd1);
        default: ;
      endcase
    end

    drain();
    $display("covered %0d command words, %0d result words, %0d timer fires",
             words_sent, words_seen, fired_seen);
    if (errors == 0) begin
      $display("timer_pool_scheduler_core: match");
    end else begin
      $display("timer_pool_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tps_pkg.sv
rtl/tps_cell.sv
rtl/timer_pool_scheduler_core.sv
tb/sv/timer_pool_checker.sv
tb/sv/testbench.sv
